/* rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int BYTE_W    = 8;
    localparam int OPCODE_W  = 4;
    localparam int LEN_W     = 64;
    localparam int MAX_W     = 32;
    localparam int KEY_W     = 32;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 2;

    localparam logic [MAX_W-1:0]    MAX_PAYLOAD_RST = 32'd1048576;
    localparam logic [6:0]          LEN7_EXT16      = 7'd126;
    localparam logic [6:0]          LEN7_EXT64      = 7'd127;
    localparam logic [CNT_W-1:0]    EXT16_BYTES     = 4'd2;
    localparam logic [CNT_W-1:0]    EXT64_BYTES     = 4'd8;
    localparam logic [CNT_W-1:0]    KEY_BYTES       = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic                   emit;
        t_kind                  kind;
        logic [BYTE_W-1:0]      data;
        logic [OPCODE_W-1:0]    opcode;
        logic                   final_fragment;
        logic                   frame_end;
    } t_result;

endpackage

/* rtl/wsd_core.sv */
// ----------------------------------------------------------------------------
// wsd_core
// Frame parser state and per-byte next-state logic; one byte per step.
// ----------------------------------------------------------------------------
module wsd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [wsd_pkg::BYTE_W-1:0]  i_byte,
    input  logic [wsd_pkg::MAX_W-1:0]   i_max_payload,
    output wsd_pkg::t_result            o_res
);
    import wsd_pkg::*;

    t_phase                 r_phase,    n_phase;
    logic [LEN_W-1:0]       r_len,      n_len;
    logic [CNT_W-1:0]       r_ext,      n_ext;
    logic [KEY_W-1:0]       r_key,      n_key;
    logic [IDX_W-1:0]       r_idx,      n_idx;
    logic                   r_masked,   n_masked;
    logic [OPCODE_W-1:0]    r_opcode,   n_opcode;
    logic                   r_fin,      n_fin;
    logic                   r_err,      n_err;

    logic [6:0]             len7;
    logic [LEN_W-1:0]       len_cand;
    logic                   len_over;
    logic [BYTE_W-1:0]      key_byte;
    logic [LEN_W-1:0]       len_dec;

    assign len7     = i_byte[6:0];
    assign len_over = len_cand > {{(LEN_W-MAX_W){1'b0}}, i_max_payload};
    assign len_dec  = r_len - {{(LEN_W-1){1'b0}}, 1'b1};

    always_comb begin
        len_cand = {{(LEN_W-7){1'b0}}, len7};
        if (r_phase == PH_EXT) begin
            len_cand = {r_len[LEN_W-BYTE_W-1:0], i_byte};
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_ext    = r_ext;
        n_key    = r_key;
        n_idx    = r_idx;
        n_masked = r_masked;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_err    = r_err;
        o_res.emit           = 1'b0;
        o_res.kind           = KIND_DATA;
        o_res.data           = '0;
        o_res.opcode         = r_opcode;
        o_res.final_fragment = r_fin;
        o_res.frame_end      = 1'b1;

        if (i_step && !r_err) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_masked = i_byte[7];
                    n_key    = '0;
                    n_idx    = '0;
                    if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                        n_len   = '0;
                        n_ext   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        n_phase = PH_EXT;
                    end else begin
                        n_len = len_cand;
                        if (len_over) begin
                            n_err      = 1'b1;
                            n_phase    = PH_HDR0;
                            o_res.emit = 1'b1;
                            o_res.kind = KIND_ERROR;
                        end else if (i_byte[7]) begin
                            n_phase = PH_MASK;
                            n_ext   = KEY_BYTES;
                        end else if (len7 == 7'd0) begin
                            n_phase    = PH_HDR0;
                            o_res.emit = 1'b1;
                            o_res.kind = KIND_EMPTY;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_EXT: begin
                    n_len = len_cand;
                    n_ext = r_ext - 4'd1;
                    if (n_ext == '0) begin
                        if (len_over) begin
                            n_err      = 1'b1;
                            n_phase    = PH_HDR0;
                            o_res.emit = 1'b1;
                            o_res.kind = KIND_ERROR;
                        end else if (r_masked) begin
                            n_phase = PH_MASK;
                            n_ext   = KEY_BYTES;
                        end else if (len_cand == '0) begin
                            n_phase    = PH_HDR0;
                            o_res.emit = 1'b1;
                            o_res.kind = KIND_EMPTY;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[KEY_W-BYTE_W-1:0], i_byte};
                    n_ext = r_ext - 4'd1;
                    if (n_ext == '0) begin
                        if (r_len == '0) begin
                            n_phase    = PH_HDR0;
                            o_res.emit = 1'b1;
                            o_res.kind = KIND_EMPTY;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_idx           = r_idx + 2'd1;
                    n_len           = len_dec;
                    o_res.emit      = 1'b1;
                    o_res.kind      = KIND_DATA;
                    o_res.data      = i_byte ^ key_byte;
                    o_res.frame_end = (len_dec == '0);
                    if (len_dec == '0) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_len    <= '0;
            r_ext    <= '0;
            r_key    <= '0;
            r_idx    <= '0;
            r_masked <= 1'b0;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_ext    <= n_ext;
            r_key    <= n_key;
            r_idx    <= n_idx;
            r_masked <= n_masked;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_err    <= n_err;
        end
    end

endmodule

/* rtl/websocket_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Parses a received WebSocket byte stream and emits unmasked payload bytes.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_ready    i_rx_byte
//   out       source     o_out_valid / i_out_ready  o_kind o_data o_opcode
//                                                   o_final_fragment o_frame_end
//   cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_data (max_payload)
//
// One byte per cycle sustained unless the result stalls; a byte moves from the
// input register through the single parser step into the result register.
// Reset is synchronous: the parser waits for header byte zero and max_payload
// returns to 1048576. A stalled result holds the input stage, which keeps
// accepting while its byte can advance in the same cycle.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [wsd_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_kind,
    output logic [wsd_pkg::BYTE_W-1:0]      o_data,
    output logic [wsd_pkg::OPCODE_W-1:0]    o_opcode,
    output logic                            o_final_fragment,
    output logic                            o_frame_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wsd_pkg::MAX_W-1:0]       i_cfg_data
);
    import wsd_pkg::*;

    logic [MAX_W-1:0]   r_max;
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_result            r_out;
    t_result            core_res;
    logic               advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    wsd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max),
        .o_res         (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_res.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_res.emit) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_data           = r_out.data;
    assign o_opcode         = r_out.opcode;
    assign o_final_fragment = r_out.final_fragment;
    assign o_frame_end      = r_out.frame_end;

endmodule

/* rtl/wsd_checker.sv */
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [1:0]                      o_kind,
    input  logic [wsd_pkg::BYTE_W-1:0]      o_data,
    input  logic                            o_frame_end
);
    import wsd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_data) && $stable(o_frame_end))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind == KIND_DATA || o_kind == KIND_EMPTY
            || o_kind == KIND_ERROR)
        else $error("undefined result kind");

    a_ctrl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_frame_end && o_data == '0)
        else $error("non-data result without frame end or with data");

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_kind == KIND_ERROR |=> !o_out_valid)
        else $error("result after length error");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_data      (o_data),
    .o_frame_end (o_frame_end)
);
